[design/erle_pkg.sv]
// Package with the types, constants and helper function of the escaped run-length encoder.
`default_nettype none

package erle_pkg;

  localparam int unsigned ByteW = 8;
  localparam logic [ByteW-1:0] EscCode = 8'd8;
  localparam logic [ByteW-1:0] RunCap = 8'd255;
  localparam logic [ByteW-1:0] RunMin = 8'd4;

  // Most encoded bytes that one input byte can cause.
  localparam int unsigned MaxBurst = 4;
  localparam int unsigned BurstCntW = $clog2(MaxBurst + 1);
  localparam int unsigned QueueDepthDflt = 8;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } erle_in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_last;
  } erle_out_t;

  // Bytes that close a held run: either escape, length, value or up to three literals.
  typedef struct packed {
    logic [2:0][ByteW-1:0] bytes;
    logic [1:0]            n;
  } erle_flush_t;

  function automatic erle_flush_t flush_f(input logic [ByteW-1:0] value,
                                          input logic [ByteW-1:0] len);
    erle_flush_t r;
    if (len >= RunMin) begin
      r.bytes[0] = EscCode;
      r.bytes[1] = len;
      r.bytes[2] = value;
      r.n        = 2'd3;
    end else begin
      r.bytes = {3{value}};
      r.n     = len[1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/escaped_run_length_encoder_core.sv]
// Escaped run-length encoder: run tracking, burst generation and output queue.
//
// Usage: the input channel takes one nonzero byte per request, with in_last set on the
// final byte of a string. The output channel gives the encoded stream one byte per
// request, with out_last set on the final encoded byte of the string. Runs of four or
// more equal bytes above 8 leave as escape 8, length, value; runs are cut at 255.
// Each accepted byte is encoded in the cycle it is taken and its zero to four result
// bytes are appended to a queue of QueueDepth entries whose head is the output register.
// An input request is taken in every cycle while the queue holds at most QueueDepth - 4
// entries; the output drains one byte per cycle while the receiver does not stall, so
// throughput is one input byte per cycle unless flush bursts or stalls fill the queue.
// When the receiver stalls, the head of the queue holds still and input is taken
// until the queue holds over QueueDepth - 4 entries, which raises in_stall_o.
// Reset empties the queue and clears the held run.
`default_nettype none

module escaped_run_length_encoder_core #(
  parameter int unsigned QueueDepth = erle_pkg::QueueDepthDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  erle_pkg::erle_in_t  in_req_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output erle_pkg::erle_out_t out_req_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import erle_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  logic [ByteW-1:0] run_value_q, run_value_d;
  logic [ByteW-1:0] run_length_q, run_length_d;
  erle_out_t        queue_q [QueueDepth];
  erle_out_t        queue_d [QueueDepth];
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             push, pop;
  logic             is_small, is_same;
  logic [ByteW-1:0] next_len;
  erle_flush_t      fl_held, fl_grown;
  logic [ByteW-1:0] item_b [MaxBurst];
  logic [BurstCntW-1:0] gen_n;
  logic [CntW-1:0]  base;

  assign in_stall_o  = cnt_q > CntW'(QueueDepth - MaxBurst);
  assign push        = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_req_o   = queue_q[0];

  assign is_small = in_req_i.in_byte <= EscCode;
  assign is_same  = (run_length_q != '0) && (in_req_i.in_byte == run_value_q);
  assign next_len = run_length_q + 8'd1;
  assign fl_held  = flush_f(run_value_q, run_length_q);
  assign fl_grown = flush_f(run_value_q, next_len);

  always_comb begin
    for (int k = 0; k < MaxBurst; k++) begin
      item_b[k] = in_req_i.in_byte;
    end
    gen_n        = '0;
    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    if (is_small) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(fl_held.n)) begin
          item_b[k] = fl_held.bytes[k];
        end
      end
      gen_n        = BurstCntW'(fl_held.n) + BurstCntW'(1);
      run_length_d = '0;
    end else if (is_same) begin
      if ((next_len == RunCap) || in_req_i.in_last) begin
        for (int k = 0; k < 3; k++) begin
          item_b[k] = fl_grown.bytes[k];
        end
        gen_n        = BurstCntW'(fl_grown.n);
        run_length_d = '0;
      end else begin
        run_length_d = next_len;
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(fl_held.n)) begin
          item_b[k] = fl_held.bytes[k];
        end
      end
      gen_n        = BurstCntW'(fl_held.n) + BurstCntW'(in_req_i.in_last);
      run_value_d  = in_req_i.in_byte;
      run_length_d = in_req_i.in_last ? 8'd0 : 8'd1;
    end
    if (in_req_i.in_last) begin
      run_value_d = '0;
    end
  end

  assign base = cnt_q - CntW'(pop);

  always_comb begin
    for (int j = 0; j < QueueDepth; j++) begin
      queue_d[j] = queue_q[j];
    end
    if (pop) begin
      for (int j = 0; j < QueueDepth - 1; j++) begin
        queue_d[j] = queue_q[j + 1];
      end
    end
    if (push) begin
      for (int k = 0; k < MaxBurst; k++) begin
        if (k < int'(gen_n)) begin
          queue_d[IdxW'(base) + IdxW'(k)].out_byte = item_b[k];
          queue_d[IdxW'(base) + IdxW'(k)].out_last =
            in_req_i.in_last && (BurstCntW'(k + 1) == gen_n);
        end
      end
    end
    cnt_d = base + (push ? CntW'(gen_n) : CntW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      run_value_q  <= '0;
      run_length_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        run_value_q  <= run_value_d;
        run_length_q <= run_length_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QueueDepth; j++) begin
      queue_q[j] <= queue_d[j];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("Output queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_length_q != RunCap)
    else $error("A run reached the cap without being sent.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && in_req_i.in_last) |=> (run_length_q == '0) && out_valid_o)
    else $error("End of string left a run held or produced no output.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && is_small) |=> out_valid_o)
    else $error("A small byte was accepted but nothing was queued.");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the escaped run-length encoder core.
module tb_top;
  import erle_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  erle_in_t  in_req_i;
  logic      in_valid_i;
  logic      in_stall_o;
  erle_out_t out_req_o;
  logic      out_valid_o;
  logic      out_stall_i;

  escaped_run_length_encoder_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_req_o  (out_req_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  erle_out_t        pending_codes[$];
  logic [ByteW-1:0] step_bytes[$];
  logic [ByteW-1:0] held_val;
  logic [ByteW-1:0] held_len;
  bit               calm;
  int               hold_left;
  int               fails;
  int               bytes_sent;
  int               strings_sent;
  int               codes_checked;
  int               cap_chunks;
  int               in_stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("escaped_run_length_encoder_core verification failed");
    $finish;
  end

  task automatic flush_held();
    if (held_len >= RunMin) begin
      step_bytes.push_back(EscCode);
      step_bytes.push_back(held_len);
      step_bytes.push_back(held_val);
      if (held_len == RunCap) cap_chunks++;
    end else begin
      for (int k = 0; k < held_len; k++) step_bytes.push_back(held_val);
    end
    held_len = '0;
  endtask

  task automatic encode_byte(input erle_in_t req);
    erle_out_t code;
    step_bytes.delete();
    if (req.in_byte <= EscCode) begin
      flush_held();
      step_bytes.push_back(req.in_byte);
    end else if (held_len != 0 && req.in_byte == held_val) begin
      held_len = held_len + 8'd1;
      if (held_len >= RunCap) flush_held();
    end else begin
      flush_held();
      held_val = req.in_byte;
      held_len = 8'd1;
    end
    if (req.in_last) begin
      flush_held();
      held_val = '0;
    end
    foreach (step_bytes[i]) begin
      code.out_byte = step_bytes[i];
      code.out_last = req.in_last && (i == step_bytes.size() - 1);
      pending_codes.push_back(code);
    end
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    erle_in_t req;
    req.in_byte = b;
    req.in_last = last;
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      in_req_i   <= erle_in_t'($urandom);
      @(posedge clk_i);
    end
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
      if (in_stall_o) in_stall_cycles++;
    end while (in_stall_o);
    encode_byte(req);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_run(input logic [ByteW-1:0] v, input int len, input logic last);
    for (int k = 0; k < len; k++) send_byte(v, last && (k == len - 1));
  endtask

  task automatic send_random_string();
    int runs;
    int len;
    int pick;
    logic [ByteW-1:0] v;
    if ($urandom_range(0, 99) < 10) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        send_byte(ByteW'($urandom_range(1, 255)), k == len - 1);
      end
    end else begin
      runs = $urandom_range(1, 4);
      for (int r = 0; r < runs; r++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) len = $urandom_range(1, 3);
        else if (pick < 80) len = $urandom_range(4, 8);
        else len = $urandom_range(9, 40);
        if ($urandom_range(0, 99) < 15) v = ByteW'($urandom_range(1, 8));
        else v = ByteW'($urandom_range(9, 255));
        send_run(v, len, r == runs - 1);
      end
    end
  endtask

  task automatic test_directed();
    send_byte(8'h01, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(EscCode, 1'b1);
    send_run(8'h09, 3, 1'b1);
    send_run(8'h09, 4, 1'b1);
    send_run(8'haa, 4, 1'b0);
    send_byte(8'h05, 1'b1);
    send_run(8'h77, 3, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b1);
    send_run(8'h30, 2, 1'b0);
    send_byte(8'h31, 1'b1);
  endtask

  task automatic test_run_cap();
    send_run(8'h9a, 259, 1'b1);
  endtask

  task automatic test_output_backpressure();
    calm      = 1'b1;
    hold_left = 150;
    for (int k = 0; k < 20; k++) begin
      send_run(ByteW'($urandom_range(9, 255)), 3, 1'b0);
      send_byte(ByteW'($urandom_range(1, 8)), k == 19);
    end
    calm = 1'b0;
  endtask

  task automatic test_no_idle();
    int start;
    start = bytes_sent;
    calm  = 1'b1;
    while (bytes_sent - start < 60) send_random_string();
    calm = 1'b0;
  endtask

  task automatic test_random_strings();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 100) send_random_string();
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 17);
      end
    end
  end

  always @(posedge clk_i) begin
    erle_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected output byte %02h last %0b", $time,
                 out_req_o.out_byte, out_req_o.out_last);
        fails++;
      end else begin
        want = pending_codes.pop_front();
        codes_checked++;
        if (want.out_byte !== out_req_o.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time,
                   want.out_byte, out_req_o.out_byte);
          fails++;
        end
        if (want.out_last !== out_req_o.out_last) begin
          $display("%0t: out_last expected %0b actual %0b", $time,
                   want.out_last, out_req_o.out_last);
          fails++;
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    held_val   = '0;
    held_len   = '0;
    calm       = 1'b0;
    hold_left  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_run_cap();
    test_output_backpressure();
    test_no_idle();
    test_random_strings();

    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Encoded %0d bytes in %0d strings, checked %0d output bytes.",
             bytes_sent, strings_sent, codes_checked);
    $display("Covered %0d full 255-byte chunks and %0d cycles of input stall.",
             cap_chunks, in_stall_cycles);
    if (fails == 0) begin
      $display("escaped_run_length_encoder_core verification clean");
    end else begin
      $display("escaped_run_length_encoder_core verification failed");
    end
    $finish;
  end

endmodule
